>>> rtl/agbkf_pkg.sv
package agbkf_pkg;

    localparam int AXIS_W = 2;
    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [30:0] ANGLE_NOISE_RST = 31'd1073742;
    localparam logic [30:0] BIAS_NOISE_RST = 31'd3221225;
    localparam logic [30:0] MEAS_NOISE_RST = 31'd536870912;
    localparam logic [31:0] TIME_STEP_RST = 32'd42949673;
    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_NOISE = 2'd0,
        CFG_BIAS_NOISE = 2'd1,
        CFG_MEAS_NOISE = 2'd2,
        CFG_TIME_STEP = 2'd3
    } cfg_idx_t;

    // Multiply steps: five predict steps, then six correct steps
    typedef enum logic [3:0] {
        STEP_ANG_P = 4'd0,
        STEP_AA_P = 4'd1,
        STEP_AB_P = 4'd2,
        STEP_BA_P = 4'd3,
        STEP_BB_P = 4'd4,
        STEP_BA_C = 4'd5,
        STEP_BB_C = 4'd6,
        STEP_AA_C = 4'd7,
        STEP_AB_C = 4'd8,
        STEP_ANG_C = 4'd9,
        STEP_BIAS_C = 4'd10
    } step_t;

    typedef struct packed {
        logic load;
        logic mul_en;
        step_t step;
        logic div_start;
        logic store;
    } ctrl_cmd_t;

    typedef struct packed {
        logic axis_ok;
        logic div_done;
        logic out_free;
    } ctrl_sts_t;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -40'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> rtl/agbkf_div.sv
module agbkf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [32:0] den,
    output logic               done,
    output logic signed [31:0] quot
);

    // Computes sat32(num * 2^30 / den), truncated; zero when den <= 0.
    // One quotient bit per cycle, the same in every case, so that two
    // dividers started together always finish together.

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] sreg_reg, sreg_next;
    logic [31:0] quo_reg, quo_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic        sat_reg, sat_next;
    logic [31:0] den_reg, den_next;
    logic signed [31:0] quot_reg, quot_next;

    logic [31:0] num_mag;
    logic        den_pos;
    logic        ovf;
    logic [32:0] trial;
    logic        ge;
    logic [31:0] qfin;

    assign num_mag = num[31] ? (~num + 32'd1) : num;
    assign den_pos = !den[32] && (den != 33'sd0);
    assign ovf = {2'b00, num_mag} >= {den[31:0], 2'b00};
    assign trial = {rem_reg, sreg_reg[31]};
    assign ge = trial >= {1'b0, den_reg};
    assign qfin = {quo_reg[30:0], ge};

    // Next-state logic
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        sreg_next = sreg_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        zero_next = zero_reg;
        sat_next = sat_reg;
        den_next = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            neg_next = num[31];
            den_next = den[31:0];
            zero_next = !den_pos;
            sat_next = ovf;
            rem_next = {2'b00, num_mag[31:2]};
            sreg_next = {num_mag[1:0], 30'd0};
            quo_next = 32'd0;
            cnt_next = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            sreg_next = {sreg_reg[30:0], 1'b0};
            quo_next = qfin;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (zero_reg)
                    quot_next = 32'sd0;
                else if (sat_reg)
                    quot_next = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                else if (neg_reg)
                    quot_next = qfin[31] ? 32'sh8000_0000 : $signed(~qfin + 32'd1);
                else
                    quot_next = qfin[31] ? 32'sh7FFF_FFFF : $signed(qfin);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sreg_reg <= sreg_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        zero_reg <= zero_next;
        sat_reg <= sat_next;
        den_reg <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> rtl/agbkf_dp.sv
module agbkf_dp #(
    parameter int NUM_AXES = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  agbkf_pkg::ctrl_cmd_t       cmd,
    output agbkf_pkg::ctrl_sts_t       sts,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [31:0]                cfg_data,
    input  logic [1:0]                 axis_sel,
    input  logic signed [31:0]         measured_angle,
    input  logic signed [31:0]         gyro_rate,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 axis_out,
    output logic signed [31:0]         angle_out,
    output logic signed [31:0]         rate_out
);

    localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    // Configuration registers
    logic [30:0] qa_reg, qb_reg, rn_reg;
    logic [31:0] dt_reg;

    // State banks
    logic signed [31:0] bank_ang [NUM_AXES];
    logic signed [31:0] bank_bias [NUM_AXES];
    logic signed [31:0] bank_aa [NUM_AXES];
    logic signed [31:0] bank_ab [NUM_AXES];
    logic signed [31:0] bank_ba [NUM_AXES];
    logic signed [31:0] bank_bb [NUM_AXES];

    // Working registers of the current transaction
    logic [1:0]         axis_reg;
    logic               ok_reg;
    logic signed [31:0] meas_reg, gyro_reg;
    logic signed [31:0] ang_reg, bias_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    logic signed [32:0] err_reg;

    // Multiplier pipeline
    logic [65:0]        prod_reg;
    logic               wb_valid_reg, wb_neg_reg;
    agbkf_pkg::step_t   wb_step_reg;

    // Output register
    logic               out_valid_reg;
    logic [1:0]         axis_out_reg;
    logic signed [31:0] angle_out_reg, rate_out_reg;

    logic [2:0]         in_axis_ext, cur_axis_ext;
    logic [IDX_W-1:0]   in_idx, cur_idx;
    logic               in_ok;
    logic signed [32:0] e_val;
    logic               div0_done, div1_done;
    logic signed [31:0] k0, k1;

    assign in_axis_ext = 3'(axis_sel);
    assign cur_axis_ext = 3'(axis_reg);
    assign in_idx = in_axis_ext[IDX_W-1:0];
    assign cur_idx = cur_axis_ext[IDX_W-1:0];
    assign in_ok = {2'b00, axis_sel} < 4'(NUM_AXES);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= agbkf_pkg::ANGLE_NOISE_RST;
            qb_reg <= agbkf_pkg::BIAS_NOISE_RST;
            rn_reg <= agbkf_pkg::MEAS_NOISE_RST;
            dt_reg <= agbkf_pkg::TIME_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (agbkf_pkg::cfg_idx_t'(cfg_index))
                agbkf_pkg::CFG_ANGLE_NOISE: qa_reg <= cfg_data[30:0];
                agbkf_pkg::CFG_BIAS_NOISE:  qb_reg <= cfg_data[30:0];
                agbkf_pkg::CFG_MEAS_NOISE:  rn_reg <= cfg_data[30:0];
                agbkf_pkg::CFG_TIME_STEP:   dt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Operand selection for the issued step
    logic signed [34:0] op_a;
    logic signed [32:0] op_b;
    logic signed [32:0] dt_s;
    logic [34:0]        a_abs;
    logic [32:0]        b_abs;
    logic [65:0]        prod_next;

    assign dt_s = $signed({1'b0, dt_reg});

    always_comb
    begin
        op_a = 35'sd0;
        op_b = dt_s;
        unique case (cmd.step)
            agbkf_pkg::STEP_ANG_P:  op_a = 35'(gyro_reg) - 35'(bias_reg);
            agbkf_pkg::STEP_AA_P:   op_a = $signed({4'b0, qa_reg}) - 35'(ab_reg) - 35'(ba_reg);
            agbkf_pkg::STEP_AB_P:   op_a = 35'(bb_reg);
            agbkf_pkg::STEP_BA_P:   op_a = 35'(bb_reg);
            agbkf_pkg::STEP_BB_P:   op_a = $signed({4'b0, qb_reg});
            agbkf_pkg::STEP_BA_C:
            begin
                op_a = 35'(k1);
                op_b = 33'(aa_reg);
            end
            agbkf_pkg::STEP_BB_C:
            begin
                op_a = 35'(k1);
                op_b = 33'(ab_reg);
            end
            agbkf_pkg::STEP_AA_C:
            begin
                op_a = 35'(k0);
                op_b = 33'(aa_reg);
            end
            agbkf_pkg::STEP_AB_C:
            begin
                op_a = 35'(k0);
                op_b = 33'(ab_reg);
            end
            agbkf_pkg::STEP_ANG_C:
            begin
                op_a = 35'(err_reg);
                op_b = 33'(k0);
            end
            agbkf_pkg::STEP_BIAS_C:
            begin
                op_a = 35'(err_reg);
                op_b = 33'(k1);
            end
            default: ;
        endcase
    end

    assign a_abs = op_a[34] ? 35'(-op_a) : op_a;
    assign b_abs = op_b[32] ? 33'(-op_b) : op_b;
    assign prod_next = 66'(a_abs[33:0]) * 66'(b_abs[31:0]);

    // Multiplier output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_valid_reg <= 1'b0;
        else
            wb_valid_reg <= cmd.mul_en;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
            wb_neg_reg <= op_a[34] ^ op_b[32];
            wb_step_reg <= cmd.step;
        end
    end

    // Writeback: round, apply sign, accumulate, saturate
    logic               wb_sh32, wb_sub;
    logic [66:0]        rnd_sum;
    logic [36:0]        mag37;
    logic signed [39:0] scaled;
    logic signed [31:0] wb_old;
    logic signed [31:0] wb_res;

    always_comb
    begin
        wb_sh32 = 1'b0;
        wb_sub = 1'b1;
        wb_old = aa_reg;
        unique case (wb_step_reg)
            agbkf_pkg::STEP_ANG_P:
            begin
                wb_sh32 = 1'b1;
                wb_sub = 1'b0;
                wb_old = ang_reg;
            end
            agbkf_pkg::STEP_AA_P:
            begin
                wb_sh32 = 1'b1;
                wb_sub = 1'b0;
                wb_old = aa_reg;
            end
            agbkf_pkg::STEP_AB_P:
            begin
                wb_sh32 = 1'b1;
                wb_old = ab_reg;
            end
            agbkf_pkg::STEP_BA_P:
            begin
                wb_sh32 = 1'b1;
                wb_old = ba_reg;
            end
            agbkf_pkg::STEP_BB_P:
            begin
                wb_sh32 = 1'b1;
                wb_sub = 1'b0;
                wb_old = bb_reg;
            end
            agbkf_pkg::STEP_BA_C:  wb_old = ba_reg;
            agbkf_pkg::STEP_BB_C:  wb_old = bb_reg;
            agbkf_pkg::STEP_AA_C:  wb_old = aa_reg;
            agbkf_pkg::STEP_AB_C:  wb_old = ab_reg;
            agbkf_pkg::STEP_ANG_C:
            begin
                wb_sub = 1'b0;
                wb_old = ang_reg;
            end
            agbkf_pkg::STEP_BIAS_C:
            begin
                wb_sub = 1'b0;
                wb_old = bias_reg;
            end
            default: ;
        endcase
    end

    assign rnd_sum = {1'b0, prod_reg} + (wb_sh32 ? (67'd1 << 31) : (67'd1 << 29));
    assign mag37 = wb_sh32 ? {2'b00, rnd_sum[66:32]} : rnd_sum[66:30];
    assign scaled = wb_neg_reg ? -$signed({3'b000, mag37}) : $signed({3'b000, mag37});
    assign wb_res = wb_sub ? agbkf_pkg::sat32(40'(wb_old) - scaled)
                           : agbkf_pkg::sat32(40'(wb_old) + scaled);

    // Working registers: load from bank, then step writebacks
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            axis_reg <= axis_sel;
            ok_reg <= in_ok;
            meas_reg <= measured_angle;
            gyro_reg <= gyro_rate;
            if (in_ok)
            begin
                ang_reg <= bank_ang[in_idx];
                bias_reg <= bank_bias[in_idx];
                aa_reg <= bank_aa[in_idx];
                ab_reg <= bank_ab[in_idx];
                ba_reg <= bank_ba[in_idx];
                bb_reg <= bank_bb[in_idx];
            end
        end
        else if (wb_valid_reg)
        begin
            unique case (wb_step_reg)
                agbkf_pkg::STEP_ANG_P, agbkf_pkg::STEP_ANG_C:  ang_reg <= wb_res;
                agbkf_pkg::STEP_AA_P, agbkf_pkg::STEP_AA_C:    aa_reg <= wb_res;
                agbkf_pkg::STEP_AB_P, agbkf_pkg::STEP_AB_C:    ab_reg <= wb_res;
                agbkf_pkg::STEP_BA_P, agbkf_pkg::STEP_BA_C:    ba_reg <= wb_res;
                agbkf_pkg::STEP_BB_P, agbkf_pkg::STEP_BB_C:    bb_reg <= wb_res;
                agbkf_pkg::STEP_BIAS_C:                        bias_reg <= wb_res;
                default: ;
            endcase
        end
        if (cmd.div_start)
            err_reg <= 33'(meas_reg) - 33'(ang_reg);
    end

    // Gain dividers, run side by side
    assign e_val = $signed({2'b00, rn_reg}) + 33'(aa_reg);

    agbkf_div u_div_k0 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (aa_reg),
        .den   (e_val),
        .done  (div0_done),
        .quot  (k0)
    );

    agbkf_div u_div_k1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (ba_reg),
        .den   (e_val),
        .done  (div1_done),
        .quot  (k1)
    );

    // State bank write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                bank_ang[i] <= 32'sd0;
                bank_bias[i] <= 32'sd0;
                bank_aa[i] <= agbkf_pkg::Q30_ONE;
                bank_ab[i] <= 32'sd0;
                bank_ba[i] <= 32'sd0;
                bank_bb[i] <= agbkf_pkg::Q30_ONE;
            end
        end
        else if (cmd.store && ok_reg)
        begin
            bank_ang[cur_idx] <= ang_reg;
            bank_bias[cur_idx] <= bias_reg;
            bank_aa[cur_idx] <= aa_reg;
            bank_ab[cur_idx] <= ab_reg;
            bank_ba[cur_idx] <= ba_reg;
            bank_bb[cur_idx] <= bb_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.store)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            axis_out_reg <= axis_reg;
            angle_out_reg <= ok_reg ? ang_reg : 32'sd0;
            rate_out_reg <= ok_reg ? agbkf_pkg::sat32(40'(gyro_reg) - 40'(bias_reg)) : 32'sd0;
        end
    end

    assign sts.axis_ok = in_ok;
    assign sts.div_done = div0_done & div1_done;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign axis_out = axis_out_reg;
    assign angle_out = angle_out_reg;
    assign rate_out = rate_out_reg;

endmodule

>>> rtl/agbkf_ctrl.sv
module agbkf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output agbkf_pkg::ctrl_cmd_t  cmd,
    input  agbkf_pkg::ctrl_sts_t  sts
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PRED  = 7'b0000010,
        S_DIVS  = 7'b0000100,
        S_DIVW  = 7'b0001000,
        S_CORR  = 7'b0010000,
        S_WB    = 7'b0100000,
        S_STORE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    agbkf_pkg::step_t step_reg, step_next;
    logic accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cmd = '0;
        cmd.step = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                begin
                    step_next = agbkf_pkg::STEP_ANG_P;
                    state_next = sts.axis_ok ? S_PRED : S_STORE;
                end
            end
            S_PRED:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == agbkf_pkg::STEP_BB_P)
                begin
                    step_next = agbkf_pkg::STEP_BA_C;
                    state_next = S_DIVS;
                end
                else
                    step_next = agbkf_pkg::step_t'(step_reg + 4'd1);
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (sts.div_done)
                    state_next = S_CORR;
            end
            S_CORR:
            begin
                cmd.mul_en = 1'b1;
                if (step_reg == agbkf_pkg::STEP_BIAS_C)
                    state_next = S_WB;
                else
                    step_next = agbkf_pkg::step_t'(step_reg + 4'd1);
            end
            S_WB:
            begin
                state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.store = sts.out_free;
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= agbkf_pkg::STEP_ANG_P;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    // Checks
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted transaction did not start processing");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> state_reg == S_DIVW)
        else $error("divider finished outside the wait state");

    a_store_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE && sts.out_free) |=> state_reg == S_IDLE)
        else $error("store did not complete the transaction");

endmodule

>>> rtl/angle_gyro_bias_kalman_filter.sv
// Two-state (angle, gyro bias) Kalman filter with one state bank per axis.
// Input channel (in_valid/in_ready): axis_sel, measured_angle, gyro_rate,
// all Q16.16. Output channel (out_valid/out_ready): axis_out, angle_out and
// the bias-corrected rate_out. One result per input transaction; an axis at
// or beyond NUM_AXES returns zeros and leaves all banks unchanged.
// Configuration: cfg_we/cfg_index/cfg_data write the angle noise, bias
// noise, measurement noise (Q2.30) and time step (Q0.32); write only while
// idle.
// Sequence per transaction: five predict multiplies, a gain divide
// (one quotient bit per cycle, both gains in parallel), six correct
// multiplies through one shared 34x32 multiplier, then write-back. An
// axis out of range goes from idle straight to the store step. One
// transaction at a time; the next is accepted once the result sits in
// the output register, even if the receiver stalls it.
// A stalled result holds until taken; the sequencer waits in its final
// step only if a new result finds the output register still full.
// Reset: banks go to angle and bias zero, covariance identity; registers
// to their defaults.
module angle_gyro_bias_kalman_filter #(
    parameter int NUM_AXES = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         axis_sel,
    input  logic signed [31:0] measured_angle,
    input  logic signed [31:0] gyro_rate,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         axis_out,
    output logic signed [31:0] angle_out,
    output logic signed [31:0] rate_out,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    agbkf_pkg::ctrl_cmd_t cmd;
    agbkf_pkg::ctrl_sts_t sts;

    agbkf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    agbkf_dp #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .axis_sel       (axis_sel),
        .measured_angle (measured_angle),
        .gyro_rate      (gyro_rate),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .axis_out       (axis_out),
        .angle_out      (angle_out),
        .rate_out       (rate_out)
    );

endmodule
